>>> rtl/plob_pkg.sv
package plob_pkg;

	localparam int unsigned LEVELS_DEF = 16;
	localparam int unsigned PRICE_W    = 32;
	localparam int unsigned QTY_W      = 32;
	localparam int unsigned TIME_W     = 64;
	localparam int unsigned DEPTH_W    = 5;
	localparam int unsigned VOL_W      = 36;
	localparam int unsigned IMB_W      = 16;
	localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd10;

	localparam logic FUNC_UPDATE = 1'b0;
	localparam logic FUNC_CLEAR  = 1'b1;
	localparam logic SIDE_BID    = 1'b0;
	localparam logic SIDE_ASK    = 1'b1;

	// command broadcast to every cell of one side
	typedef struct packed {
		logic              en;
		logic              clear;
		logic              is_ask;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   qty;
	} plob_cmd_t;

	// what a cell tells its right-hand neighbor
	typedef struct packed {
		logic               valid;
		logic               hit;
		logic               ranks_above;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   qty;
	} plob_link_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BOOK,
		ST_SUM,
		ST_DIV,
		ST_OUT
	} plob_state_t;

endpackage

>>> rtl/plob_cell.sv
module plob_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  plob_pkg::plob_cmd_t  cmd,
	input  plob_pkg::plob_link_t left,
	input  plob_pkg::plob_link_t right,
	output plob_pkg::plob_link_t status
);
	import plob_pkg::*;

	logic               valid_q;
	logic [PRICE_W-1:0] price_q;
	logic [QTY_W-1:0]   qty_q;
	logic               hit;
	logic               above;
	logic               left_above;

	assign hit   = valid_q && price_q == cmd.price;
	assign above = valid_q && (cmd.is_ask ? price_q < cmd.price : price_q > cmd.price);

	// hit travels as "any cell at or left of me matched"
	assign status.valid       = valid_q;
	assign status.hit         = hit || left.hit;
	assign status.ranks_above = above;
	assign status.price       = price_q;
	assign status.qty         = qty_q;

	// left neighbor is absent for cell 0: tied valid with ranks_above set
	assign left_above = left.ranks_above;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (cmd.en) begin
			if (right.hit && cmd.qty == '0) begin
				// removal somewhere in the row
				if (status.hit) begin
					valid_q <= right.valid;
					price_q <= right.price;
					qty_q   <= right.qty;
				end
			end else if (right.hit) begin
				if (hit) qty_q <= cmd.qty;
			end else if (cmd.qty != '0) begin
				// insert: first cell not ranking above takes new, rest shift
				if (!above && valid_q) begin
					if (left_above) begin
						price_q <= cmd.price;
						qty_q   <= cmd.qty;
					end else begin
						price_q <= left.price;
						qty_q   <= left.qty;
					end
				end else if (!valid_q && left.valid) begin
					valid_q <= 1'b1;
					if (left_above) begin
						price_q <= cmd.price;
						qty_q   <= cmd.qty;
					end else begin
						price_q <= left.price;
						qty_q   <= left.qty;
					end
				end
			end
		end
	end
endmodule

>>> rtl/plob_side.sv
module plob_side #(
	parameter int unsigned LEVELS = plob_pkg::LEVELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  plob_pkg::plob_cmd_t          cmd,
	output logic [plob_pkg::PRICE_W-1:0] best,
	output logic                         drop,
	output logic [LEVELS-1:0]            valid,
	output logic [LEVELS*plob_pkg::QTY_W-1:0] qtys
);
	import plob_pkg::*;

	plob_link_t link [LEVELS+1];

	// virtual cell left of cell 0: valid, ranks above the new price
	assign link[0] = '{valid: 1'b1, hit: 1'b0, ranks_above: 1'b1, price: '0, qty: '0};

	for (genvar g = 0; g < LEVELS; g++) begin : g_cell
		plob_link_t r;
		assign r = '{valid: link[g+2 > LEVELS ? LEVELS : g+2].valid && (g+1 < LEVELS),
			hit: link[LEVELS].hit, ranks_above: 1'b0,
			price: link[g+2 > LEVELS ? LEVELS : g+2].price,
			qty: link[g+2 > LEVELS ? LEVELS : g+2].qty};
		plob_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.left   (link[g]),
			.right  (r),
			.status (link[g+1])
		);
		assign valid[g] = link[g+1].valid;
		assign qtys[g*QTY_W +: QTY_W] = link[g+1].qty;
	end

	assign best = link[1].valid ? link[1].price : '0;
	// full side, no match, new price did not land: either dropped
	assign drop = cmd.en && !link[LEVELS].hit && cmd.qty != '0 && link[LEVELS].valid;
endmodule

>>> rtl/plob_div.sv
module plob_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [plob_pkg::VOL_W-1:0]  bv,
	input  logic [plob_pkg::VOL_W-1:0]  av,
	output logic                        done,
	output logic [plob_pkg::IMB_W-1:0]  imb
);
	import plob_pkg::*;

	// quotient never exceeds 32768, one bit above the result width is enough
	localparam int unsigned QB = IMB_W + 1;
	localparam int unsigned RW = VOL_W + QB + 2;

	logic [VOL_W:0]   den;
	logic [VOL_W-1:0] mag;
	logic [RW-1:0]    rem_q;
	logic [RW-1:0]    dsr_q;
	logic [QB-1:0]    quo_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             neg_q;
	logic             zero_q;
	logic             fits;

	assign den  = {1'b0, bv} + {1'b0, av};
	assign mag  = (bv >= av) ? bv - av : av - bv;
	assign fits = rem_q >= dsr_q;

	// restoring division of (mag*65536 + den) by 2*den, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(QB);
				rem_q  <= RW'({mag, 16'b0}) + RW'(den);
				dsr_q  <= RW'({den, 1'b0}) << (QB - 1);
				quo_q  <= '0;
				neg_q  <= bv < av;
				zero_q <= bv == '0 && av == '0;
			end else if (busy_q) begin
				if (fits) begin
					rem_q <= rem_q - dsr_q;
					quo_q <= {quo_q[QB-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[QB-2:0], 1'b0};
				end
				dsr_q <= dsr_q >> 1;
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (zero_q) imb = '0;
		else if (!neg_q) imb = (quo_q > QB'(32767)) ? 16'h7FFF : quo_q[IMB_W-1:0];
		else imb = (quo_q > QB'(32768)) ? 16'h8000 : IMB_W'(-quo_q);
	end
endmodule

>>> rtl/price_level_order_book.sv
// Price-level order book: a bid row and an ask row of LEVELS cells each, kept sorted
// best first (bids descending, asks ascending). One update moves the whole row at
// once; the volume sum then walks the best min(volume_depth, LEVELS) levels one per
// cycle, and the Q1.15 imbalance comes from a 17-step restoring divider. A new input
// beat is taken only once the previous result has been accepted on the output.
// volume_depth is written on the cfg channel while the block is idle.
module price_level_order_book #(
	parameter int unsigned LEVELS = plob_pkg::LEVELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [plob_pkg::DEPTH_W-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic                          side,
	input  logic [plob_pkg::PRICE_W-1:0]  price,
	input  logic [plob_pkg::QTY_W-1:0]    quantity,
	input  logic [plob_pkg::TIME_W-1:0]   timestamp,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [plob_pkg::PRICE_W-1:0]  bid_top,
	output logic [plob_pkg::PRICE_W-1:0]  ask_top,
	output logic [32:0]                   mid_halfticks,
	output logic signed [32:0]            spread,
	output logic [plob_pkg::VOL_W-1:0]    bid_volume,
	output logic [plob_pkg::VOL_W-1:0]    ask_volume,
	output logic signed [plob_pkg::IMB_W-1:0] imbalance,
	output logic [plob_pkg::TIME_W-1:0]   last_update_time,
	output logic                          level_dropped
);
	import plob_pkg::*;

	localparam int unsigned IDX_W  = $clog2(LEVELS + 1);
	localparam int unsigned SLOT_W = $clog2(LEVELS);

	plob_state_t state_q, state_d;
	plob_cmd_t   bcmd, acmd;
	logic [DEPTH_W-1:0] depth_q;
	logic [PRICE_W-1:0] bb, ba;
	logic bdrop, adrop;
	logic [LEVELS-1:0] bvalid, avalid;
	logic [LEVELS*QTY_W-1:0] bq, aq;
	logic [IDX_W-1:0] idx_q;
	logic [SLOT_W-1:0] slot;
	logic [VOL_W-1:0] bsum_q, asum_q;
	logic div_start, div_done;
	logic [IMB_W-1:0] imb;
	logic acc;
	logic upd;

	assign acc = in_valid && in_ready;
	assign upd = acc && func == FUNC_UPDATE && price != '0;
	assign cfg_ready = state_q == ST_IDLE;
	assign in_ready  = state_q == ST_IDLE;

	always_comb begin
		bcmd = '{en: upd && side == SIDE_BID, clear: acc && func == FUNC_CLEAR,
			is_ask: 1'b0, price: price, qty: quantity};
		acmd = '{en: upd && side == SIDE_ASK, clear: acc && func == FUNC_CLEAR,
			is_ask: 1'b1, price: price, qty: quantity};
	end

	plob_side #(.LEVELS(LEVELS)) u_bid (.clk, .arst_n, .cmd(bcmd), .best(bb),
		.drop(bdrop), .valid(bvalid), .qtys(bq));
	plob_side #(.LEVELS(LEVELS)) u_ask (.clk, .arst_n, .cmd(acmd), .best(ba),
		.drop(adrop), .valid(avalid), .qtys(aq));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			depth_q <= DEPTH_RESET;
			last_update_time <= '0;
			level_dropped <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) depth_q <= cfg_data;
			if (acc) begin
				last_update_time <= func == FUNC_CLEAR ? '0 : timestamp;
				level_dropped    <= bdrop || adrop;
			end
		end
	end

	// only read while idx_q < LEVELS, so the low bits address the level
	assign slot = idx_q[SLOT_W-1:0];

	// sum walks one level per cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_BOOK) begin
			idx_q  <= '0;
			bsum_q <= '0;
			asum_q <= '0;
		end else if (state_q == ST_SUM) begin
			if (32'(idx_q) < LEVELS && 32'(idx_q) < 32'(depth_q)) begin
				if (bvalid[slot])
					bsum_q <= bsum_q + VOL_W'(bq[slot*QTY_W +: QTY_W]);
				if (avalid[slot])
					asum_q <= asum_q + VOL_W'(aq[slot*QTY_W +: QTY_W]);
			end
			idx_q <= idx_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: if (acc) state_d = ST_BOOK;
			ST_BOOK: state_d = ST_SUM;
			ST_SUM: if (32'(idx_q) >= LEVELS || 32'(idx_q) >= 32'(depth_q)) begin
				state_d = ST_DIV;
				div_start = 1'b1;
			end
			ST_DIV: if (div_done) state_d = ST_OUT;
			ST_OUT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	plob_div u_div (.clk, .arst_n, .start(div_start), .bv(bsum_q), .av(asum_q),
		.done(div_done), .imb(imb));

	assign out_valid = state_q == ST_OUT;
	assign bid_top = bb;
	assign ask_top = ba;
	assign mid_halfticks = (bb != '0 && ba != '0) ? {1'b0, bb} + {1'b0, ba} : '0;
	assign spread = (bb != '0 && ba != '0) ? $signed({1'b0, ba} - {1'b0, bb}) : '0;
	assign bid_volume = bsum_q;
	assign ask_volume = asum_q;
	assign imbalance = $signed(imb);
endmodule

>>> rtl/plob_checker.sv
module plob_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] bid_top,
	input logic [31:0] ask_top,
	input logic [32:0] mid_halfticks
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("out beat dropped");
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken with result pending");
	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (bid_top == 0 || ask_top == 0) |-> mid_halfticks == 0)
		else $error("mid with empty side");
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind price_level_order_book plob_checker u_plob_checker (.clk, .arst_n, .in_valid, .in_ready,
	.out_valid, .out_ready, .bid_top, .ask_top, .mid_halfticks);
